>>> design/linear_probe_hash_table_top_assert.svh
// Assertion macros for the linear probing hash table top level.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht: same-cycle check failed");
`define LPHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht: next-cycle check failed");
`else
`define LPHT_ASSERT_NOW(label, ante, cons)
`define LPHT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/lpht_pkg.sv
// Shared types, codes and the microcode table of the linear probing hash table.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package lpht_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int KEY_BYTES_DEF   = 8;

    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY_KEY = 2'd3
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_CLEAR     = 4'd1,
        OP_ACCEPT    = 4'd2,
        OP_MOD       = 4'd3,
        OP_SETIDX    = 4'd4,
        OP_READ      = 4'd5,
        OP_NEXT      = 4'd6,
        OP_RES_HIT   = 4'd7,
        OP_RES_MISS  = 4'd8,
        OP_WRITE     = 4'd9,
        OP_RES_FULL  = 4'd10,
        OP_RES_EMPTY = 4'd11,
        OP_PUSH      = 4'd12
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS     = 4'd0,
        C_CLR_LAST   = 4'd1,
        C_IN_VALID   = 4'd2,
        C_KEY_ZERO   = 4'd3,
        C_STOP       = 4'd5,
        C_LAST_PROBE = 4'd6,
        C_SEARCH     = 4'd7,
        C_MATCH      = 4'd8,
        C_OUT_FREE   = 4'd9
    } cond_t;

    // microcode addresses
    typedef enum logic [4:0] {
        S_CLEAR    = 5'd0,
        S_IDLE     = 5'd1,
        S_CHECK    = 5'd2,
        S_MOD      = 5'd3,
        S_SETIDX   = 5'd4,
        S_PROBE_RD = 5'd5,
        S_PROBE_EV = 5'd6,
        S_NEXT     = 5'd7,
        S_DECIDE   = 5'd8,
        S_SRCH     = 5'd9,
        S_SHIT     = 5'd10,
        S_MISS     = 5'd11,
        S_INS      = 5'd12,
        S_EXHAUST  = 5'd13,
        S_FULL     = 5'd14,
        S_ZKEY     = 5'd15,
        S_ZREJ     = 5'd16,
        S_OUT      = 5'd17
    } step_t;

    // jt taken when the condition holds, jf otherwise
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jt;
        step_t jf;
    } uword_t;

    typedef struct packed {
        logic clr_last;
        logic clr_done;
        logic in_valid;
        logic key_zero;
        logic stop;
        logic last_probe;
        logic search;
        logic match;
        logic out_free;
    } dp_flags_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            S_CLEAR:    w = '{OP_CLEAR,     C_CLR_LAST,   S_IDLE,     S_CLEAR};
            S_IDLE:     w = '{OP_ACCEPT,    C_IN_VALID,   S_CHECK,    S_IDLE};
            S_CHECK:    w = '{OP_NONE,      C_KEY_ZERO,   S_ZKEY,     S_MOD};
            S_MOD:      w = '{OP_MOD,       C_ALWAYS,     S_SETIDX,   S_SETIDX};
            S_SETIDX:   w = '{OP_SETIDX,    C_ALWAYS,     S_PROBE_RD, S_PROBE_RD};
            S_PROBE_RD: w = '{OP_READ,      C_ALWAYS,     S_PROBE_EV, S_PROBE_EV};
            S_PROBE_EV: w = '{OP_NONE,      C_STOP,       S_DECIDE,   S_NEXT};
            S_NEXT:     w = '{OP_NEXT,      C_LAST_PROBE, S_EXHAUST,  S_PROBE_RD};
            S_DECIDE:   w = '{OP_NONE,      C_SEARCH,     S_SRCH,     S_INS};
            S_SRCH:     w = '{OP_NONE,      C_MATCH,      S_SHIT,     S_MISS};
            S_SHIT:     w = '{OP_RES_HIT,   C_ALWAYS,     S_OUT,      S_OUT};
            S_MISS:     w = '{OP_RES_MISS,  C_ALWAYS,     S_OUT,      S_OUT};
            S_INS:      w = '{OP_WRITE,     C_ALWAYS,     S_OUT,      S_OUT};
            S_EXHAUST:  w = '{OP_NONE,      C_SEARCH,     S_MISS,     S_FULL};
            S_FULL:     w = '{OP_RES_FULL,  C_ALWAYS,     S_OUT,      S_OUT};
            S_ZKEY:     w = '{OP_NONE,      C_SEARCH,     S_MISS,     S_ZREJ};
            S_ZREJ:     w = '{OP_RES_EMPTY, C_ALWAYS,     S_OUT,      S_OUT};
            S_OUT:      w = '{OP_PUSH,      C_OUT_FREE,   S_IDLE,     S_OUT};
            default:    w = '{OP_NONE,      C_ALWAYS,     S_IDLE,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> design/lpht_req_if.sv
// Request channel: command, key and value with valid/ready.
// Depends on lpht_pkg for field widths.
`default_nettype none

interface lpht_req_if;
    import lpht_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink (input valid, input cmd, input key, input value, output ready);
endinterface

`default_nettype wire

>>> design/lpht_rsp_if.sv
// Response channel: found flag, read value and status with valid/ready.
// Depends on lpht_pkg for field widths.
`default_nettype none

interface lpht_rsp_if;
    import lpht_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      found;
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output found, output read_value, output status,
                    input ready);
    modport sink (input valid, input found, input read_value, input status,
                  output ready);
endinterface

`default_nettype wire

>>> design/lpht_seq.sv
// Microcode sequencer: step counter, control ROM and condition select.
// Depends on lpht_pkg (ucode table, op/cond/step types, datapath flags).
`default_nettype none

module lpht_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpht_pkg::dp_flags_t  flags,
    output lpht_pkg::op_t        op
);
    import lpht_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t word;
    logic   take;

    assign word = ucode(pc_reg);
    assign op   = word.op;

    always_comb
    begin
        case (word.cond)
            C_ALWAYS:     take = 1'b1;
            C_CLR_LAST:   take = flags.clr_last;
            C_IN_VALID:   take = flags.in_valid;
            C_KEY_ZERO:   take = flags.key_zero;
            C_STOP:       take = flags.stop;
            C_LAST_PROBE: take = flags.last_probe;
            C_SEARCH:     take = flags.search;
            C_MATCH:      take = flags.match;
            C_OUT_FREE:   take = flags.out_free;
            default:      take = 1'b1;
        endcase
        pc_next = take ? word.jt : word.jf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> design/lpht_dp.sv
// Datapath: key/value memories, byte-sum hash with reciprocal-multiply modulo,
// probe index and counters, result and output registers.
// Depends on lpht_pkg, lpht_req_if and lpht_rsp_if.
`default_nettype none

module lpht_dp #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lpht_pkg::op_t       op,
    output lpht_pkg::dp_flags_t flags,
    lpht_req_if.sink            req,
    lpht_rsp_if.source          rsp
);
    import lpht_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int KW = 8 * KEY_BYTES;
    localparam int SW = $clog2(255 * KEY_BYTES + 1);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int MW = SW + CW;
    // quotient = (sum * RMUL) >> RS, exact for every sum below 2**SW
    localparam int RS = SW + IW;
    localparam int RW = RS + 1;
    localparam int PW = SW + RW;
    localparam logic [PW-1:0] RMUL =
        PW'(((64'd1 << RS) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
    localparam logic [MW-1:0] SLOTS_M  = MW'(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);

    logic [KW-1:0]          key_mem [TABLE_SLOTS];
    logic [VALUE_W-1:0]     val_mem [TABLE_SLOTS];

    cmd_t                   cmd_reg, cmd_next;
    logic [KW-1:0]          key_reg, key_next;
    logic [VALUE_W-1:0]     value_reg, value_next;
    logic [SW-1:0]          rem_reg, rem_next;
    logic [SW-1:0]          quo_reg, quo_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic [IW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic                   clr_done_reg, clr_done_next;
    logic [KW-1:0]          rd_key_reg, rd_key_next;
    logic [VALUE_W-1:0]     rd_val_reg, rd_val_next;
    logic                   res_found_reg, res_found_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    status_t                res_status_reg, res_status_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    status_t                out_status_reg, out_status_next;

    logic [SW-1:0]          sum;
    logic [PW-1:0]          mul_prod;
    logic [MW-1:0]          quo_slots;
    logic                   out_free;
    logic                   push;
    logic                   mem_we;
    logic [IW-1:0]          mem_addr;
    logic [KW-1:0]          mem_key;

    // home slot numerator: unsigned sum of the key bytes
    always_comb
    begin
        sum = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            sum = sum + SW'(req.key[8*b +: 8]);
        end
    end

    assign mul_prod  = PW'(rem_reg) * RMUL;
    assign quo_slots = MW'(quo_reg) * SLOTS_M;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign push      = (op == OP_PUSH) && out_free;
    assign req.ready = (op == OP_ACCEPT);

    assign flags.clr_last   = (clr_cnt_reg == LAST_IDX);
    assign flags.clr_done   = clr_done_reg;
    assign flags.in_valid   = req.valid;
    assign flags.key_zero   = (key_reg == '0);
    assign flags.stop       = (rd_key_reg == key_reg) || (rd_key_reg == '0);
    assign flags.last_probe = (cnt_reg == LAST_IDX);
    assign flags.search     = (cmd_reg == CMD_SEARCH);
    assign flags.match      = (rd_key_reg == key_reg);
    assign flags.out_free   = out_free;

    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_done_next   = clr_done_reg;
        rd_key_next     = rd_key_reg;
        rd_val_next     = rd_val_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_addr        = idx_reg;
        mem_key         = key_reg;

        case (op)
            OP_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_key      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX)
                begin
                    clr_done_next = 1'b1;
                end
            end
            OP_ACCEPT:
            begin
                cmd_next   = cmd_t'(req.cmd);
                key_next   = req.key[KW-1:0];
                value_next = req.value;
                rem_next   = sum;
            end
            OP_MOD:
            begin
                quo_next = SW'(mul_prod >> RS);
            end
            OP_SETIDX:
            begin
                idx_next = IW'(MW'(rem_reg) - quo_slots);
                cnt_next = '0;
            end
            OP_READ:
            begin
                rd_key_next = key_mem[idx_reg];
                rd_val_next = val_mem[idx_reg];
            end
            OP_NEXT:
            begin
                idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_RES_HIT:
            begin
                res_found_next  = 1'b1;
                res_value_next  = rd_val_reg;
                res_status_next = ST_OK;
            end
            OP_RES_MISS:
            begin
                res_found_next  = 1'b0;
                res_value_next  = '0;
                res_status_next = ST_NOT_FOUND;
            end
            OP_WRITE:
            begin
                mem_we          = 1'b1;
                res_found_next  = 1'b1;
                res_value_next  = '0;
                res_status_next = ST_OK;
            end
            OP_RES_FULL:
            begin
                res_found_next  = 1'b0;
                res_value_next  = '0;
                res_status_next = ST_FULL;
            end
            OP_RES_EMPTY:
            begin
                res_found_next  = 1'b0;
                res_value_next  = '0;
                res_status_next = ST_EMPTY_KEY;
            end
            default:
            begin
            end
        endcase
    end

    // output register: holds a transaction until the receiver takes it
    always_comb
    begin
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (push)
        begin
            out_valid_next  = 1'b1;
            out_found_next  = res_found_reg;
            out_value_next  = res_value_reg;
            out_status_next = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_addr] <= mem_key;
        end
        if (op == OP_WRITE)
        begin
            val_mem[idx_reg] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        rd_key_reg     <= rd_key_next;
        rd_val_reg     <= rd_val_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            clr_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            clr_done_reg  <= clr_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> design/linear_probe_hash_table_top.sv
// Linear probing hash table: open-addressed key/value store, key byte-sum home slot.
// req: one transaction per operation (cmd 0 insert/update, 1 search; key; value).
// rsp: one transaction per request (found, read_value, status 0 ok / 1 not found /
//      2 table full / 3 empty key rejected).
// After reset the key store is cleared one slot per cycle; req.ready stays low
// until every slot has been cleared.
// One request is worked at a time by a microcoded sequencer. From the request
// transaction to rsp.valid it runs a key check, the hash steps (reciprocal
// multiply, index load), a read and a compare step per probe with an advance
// step between probes, then the result steps. A zero key skips hashing and
// probing.
// The result sits in an output register; req.ready rises the cycle after the
// result is loaded there, so the next request is taken while the receiver
// still holds off. If the receiver stalls with a result pending, the following
// result waits in the sequencer until the output register frees.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_seq and lpht_dp.
`default_nettype none
`include "linear_probe_hash_table_top_assert.svh"

module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp
);
    import lpht_pkg::*;

    op_t       op;
    dp_flags_t flags;

    lpht_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    lpht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .flags (flags),
        .req   (req),
        .rsp   (rsp)
    );

    `LPHT_ASSERT_NOW(a_no_accept_before_clear, req.ready, flags.clr_done)
    `LPHT_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready)
    `LPHT_ASSERT_NOW(a_found_matches_ok, rsp.valid, rsp.found == (rsp.status == ST_OK))
    `LPHT_ASSERT_NOW(a_value_zero_on_fail, rsp.valid && rsp.status != ST_OK, rsp.read_value == 0)

endmodule

`default_nettype wire
